[rtl/scc_pkg.sv]
// Shared types, constants and the prescaler period table for the countdown clock.
package scc_pkg;

    localparam int MIN_W   = 8;
    localparam int SEC_W   = 6;
    localparam int CENTI_W = 7;
    localparam int RATIO_W = 3;
    localparam int PRE_W   = 8;

    localparam logic [SEC_W-1:0]   SEC_MAX   = SEC_W'(59);
    localparam logic [CENTI_W-1:0] CENTI_MAX = CENTI_W'(99);

    localparam logic [RATIO_W-1:0] RATIO_LAST = RATIO_W'(4);

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [CENTI_W-1:0] centis;
        logic               done;
    } result_t;

    function automatic logic [PRE_W-1:0] period_for(input logic [RATIO_W-1:0] idx);
        logic [PRE_W-1:0] p;
        begin
            case (idx)
                RATIO_W'(0): p = PRE_W'(20);
                RATIO_W'(1): p = PRE_W'(16);
                RATIO_W'(2): p = PRE_W'(13);
                RATIO_W'(3): p = PRE_W'(11);
                default:     p = PRE_W'(10);
            endcase
            return p;
        end
    endfunction

endpackage

[rtl/scaled_countdown_clock.sv]
// Minutes / seconds / centiseconds countdown clock driven by prescaled ticks.
//
// Input channel (in_valid / in_stall): each item is either a tick
// (opcode 0) or a load of time and speed ratio (opcode 1). Load fields are
// ignored on a tick. Output channel (out_valid / out_stall): one result item
// per input item, giving the time left and the time_up flag after that item.
//
// Each result is registered in the output register, or in the skid register
// when the output stalls. One item per cycle is taken while in_stall is low;
// the clock state and prescaler take a single counter-logic step on accept.
//
// A skid register sits behind the output register, so an item is still taken
// while a result waits on a stalled receiver; in_stall rises only when both
// the output and skid registers hold results. Results are never dropped or
// reordered.
//
// Reset (rst_n low, asynchronous) clears the time, the done flag, the ratio
// and the prescaler, and empties the output side.
module scaled_countdown_clock
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [scc_pkg::MIN_W-1:0]     load_minutes,
    input  logic [scc_pkg::SEC_W-1:0]     load_seconds,
    input  logic [scc_pkg::CENTI_W-1:0]   load_centiseconds,
    input  logic [scc_pkg::RATIO_W-1:0]   load_ratio,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scc_pkg::MIN_W-1:0]     minutes_left,
    output logic [scc_pkg::SEC_W-1:0]     seconds_left,
    output logic [scc_pkg::CENTI_W-1:0]   centiseconds_left,
    output logic                          time_up
);
    import scc_pkg::*;

    logic [MIN_W-1:0]   min_reg,   min_next;
    logic [SEC_W-1:0]   sec_reg,   sec_next;
    logic [CENTI_W-1:0] centi_reg, centi_next;
    logic               done_reg,  done_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [PRE_W-1:0]   pre_reg,   pre_next;

    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;
    logic    accept;

    assign accept   = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_comb
    begin
        min_next   = min_reg;
        sec_next   = sec_reg;
        centi_next = centi_reg;
        done_next  = done_reg;
        ratio_next = ratio_reg;
        pre_next   = pre_reg;
        if (opcode == OP_LOAD)
        begin
            min_next   = load_minutes;
            sec_next   = load_seconds;
            centi_next = load_centiseconds;
            ratio_next = load_ratio;
            done_next  = (load_minutes == '0) && (load_seconds == '0)
                         && (load_centiseconds == '0);
        end
        else if (pre_reg == period_for(ratio_reg))
        begin
            pre_next = '0;
            if (!done_reg)
            begin
                if (centi_reg != '0)
                begin
                    centi_next = centi_reg - CENTI_W'(1);
                end
                else if (sec_reg != '0)
                begin
                    centi_next = CENTI_MAX;
                    sec_next   = sec_reg - SEC_W'(1);
                end
                else if (min_reg != '0)
                begin
                    centi_next = CENTI_MAX;
                    sec_next   = SEC_MAX;
                    min_next   = min_reg - MIN_W'(1);
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
        end
        else
        begin
            pre_next = pre_reg + PRE_W'(1);
        end
        res.minutes = min_next;
        res.seconds = sec_next;
        res.centis  = centi_next;
        res.done    = done_next;
    end

    // clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            sec_reg   <= '0;
            centi_reg <= '0;
            done_reg  <= 1'b0;
            ratio_reg <= '0;
            pre_reg   <= '0;
        end
        else if (accept)
        begin
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            centi_reg <= centi_next;
            done_reg  <= done_next;
            ratio_reg <= ratio_next;
            pre_reg   <= pre_next;
        end
    end

    // output and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign minutes_left      = out_reg.minutes;
    assign seconds_left      = out_reg.seconds;
    assign centiseconds_left = out_reg.centis;
    assign time_up           = out_reg.done;

endmodule
